@@ rtl/stse_pkg.sv @@
// Shared types, constants and sine table generator for the sine tone synthesizer.
package stse_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned DUTY_BITS_DEF   = 10;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned ENV_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // x/255 == (x * RECIP_255) >> RECIP_SHIFT, exact for x below 2^31/127
  localparam int unsigned        RECIP_W     = 24;
  localparam int unsigned        RECIP_SHIFT = 31;
  localparam logic [RECIP_W-1:0] RECIP_255   = 24'd8421505;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ENV    = 2'd1,
    CMD_STEP   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE     = 2'd0,
    CFG_FALL     = 2'd1,
    CFG_DUTY_MAX = 2'd2
  } cfg_idx_e;

  // sin(pi/2 * r / 2^lg) in Q30, Taylor series
  function automatic logic [63:0] quarter_sine(int unsigned r, int unsigned lg);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] t;
    logic [63:0] plus;
    logic [63:0] minus;
    x     = (64'(r) * HALF_PI_Q30) >> lg;
    x2    = (x * x) >> 30;
    term  = x;
    plus  = '0;
    minus = '0;
    for (int n = 0; n < 20; n++) begin
      if (term != '0) begin
        if (n % 2 == 1) minus = minus + term;
        else            plus  = plus + term;
        t = (term * x2) >> 30;
        case (n)
          0:  term = t / 64'd6;
          1:  term = t / 64'd20;
          2:  term = t / 64'd42;
          3:  term = t / 64'd72;
          4:  term = t / 64'd110;
          5:  term = t / 64'd156;
          6:  term = t / 64'd210;
          7:  term = t / 64'd272;
          8:  term = t / 64'd342;
          9:  term = t / 64'd420;
          10: term = t / 64'd506;
          11: term = t / 64'd600;
          12: term = t / 64'd702;
          13: term = t / 64'd812;
          14: term = t / 64'd930;
          15: term = t / 64'd1056;
          16: term = t / 64'd1190;
          17: term = t / 64'd1332;
          18: term = t / 64'd1482;
          19: term = t / 64'd1640;
          default: term = '0;
        endcase
      end
    end
    if (minus >= plus) return '0;
    plus = plus - minus;
    return (plus > ONE_Q30) ? ONE_Q30 : plus;
  endfunction

  // round(mid + (mid-1)*sin(2*pi*i/2^lg)) for a table of 2^lg entries
  function automatic logic [15:0] sine_entry(int unsigned i, int unsigned lg,
                                             int unsigned dbits);
    int unsigned a;
    int unsigned quad;
    int unsigned r;
    logic [63:0] s;
    logic [63:0] mid;
    logic [63:0] mag;
    a    = 4 * i;
    quad = a >> lg;
    r    = a & ((1 << lg) - 1);
    s    = (quad % 2 == 1) ? quarter_sine((1 << lg) - r, lg) : quarter_sine(r, lg);
    mid  = 64'd1 << (dbits - 1);
    mag  = (s * (mid - 64'd1) + (ONE_Q30 >> 1)) >> 30;
    return (quad >= 2) ? 16'(mid - mag) : 16'(mid + mag);
  endfunction

endpackage

@@ rtl/stse_ifs.sv @@
// Valid/ready channel interfaces: command input, duty output, register writes.
interface stse_in_if;
  import stse_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [PHASE_W-1:0] phase_step;
  modport source (output valid, cmd, phase_step, input ready);
  modport sink   (input valid, cmd, phase_step, output ready);
endinterface

interface stse_out_if #(
  parameter int unsigned DUTY_BITS = stse_pkg::DUTY_BITS_DEF
);
  import stse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] duty;
  logic [ENV_W-1:0]     envelope_level;
  logic                 active;
  modport source (output valid, duty, envelope_level, active, input ready);
  modport sink   (input valid, duty, envelope_level, active, output ready);
endinterface

interface stse_cfg_if;
  import stse_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sine_tone_synth_with_envelope_top.sv @@
// Sine tone synthesizer with attack/release envelope, producing PWM duty values.
// Takes one command item per clock unless back-pressure from the output fills every stage.
// Envelope and set-step commands act in the cycle they are accepted and return nothing.
// A sample tick passes four register stages on its way to the output: synchronous sine
// table read, magnitude-by-envelope multiply, reciprocal multiply for the divide by
// 255, then clamp into the output register.
// The stages advance independently, so commands keep flowing while a result waits
// at the output as long as an empty stage remains. TABLE_DEPTH must be a power of
// two; the table is indexed by the top log2(TABLE_DEPTH) phase bits. No clearing
// pass after reset.
module sine_tone_synth_with_envelope_top #(
  parameter int unsigned TABLE_DEPTH = stse_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned DUTY_BITS   = stse_pkg::DUTY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stse_in_if.sink   in_i,
  stse_out_if.source out_o,
  stse_cfg_if.sink  cfg_i
);
  import stse_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned MAG_W  = DUTY_BITS - 1;
  localparam int unsigned PROD_W = MAG_W + ENV_W;
  localparam int unsigned SCL_W  = PROD_W + RECIP_W;
  localparam logic [DUTY_BITS-1:0] DUTY_MID = {1'b1, {(DUTY_BITS-1){1'b0}}};

  typedef logic [DUTY_BITS-1:0] rom_t [TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [15:0] e;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      e      = sine_entry(int'(i), IDX_W, DUTY_BITS);
      rom[i] = e[DUTY_BITS-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // architectural state and registers
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [PHASE_W-1:0]   step_q, step_d;
  logic [ENV_W-1:0]     env_q, env_d;
  logic                 live_q, live_d;
  logic [ENV_W-1:0]     rise_q, fall_q;
  logic [DUTY_BITS-1:0] duty_max_q;

  // pipeline
  logic                 s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic [DUTY_BITS-1:0] s1_rom_q;
  logic [ENV_W-1:0]     s1_env_q, s2_env_q, s3_env_q, out_env_q;
  logic                 s2_neg_q, s3_neg_q;
  logic [PROD_W-1:0]    s2_prod_q;
  logic [MAG_W-1:0]     s3_sc_q;
  logic [DUTY_BITS-1:0] out_duty_q;

  logic out_free, s3_free, s2_free, s1_free;
  logic in_acc, sample_acc;
  cmd_e cmd;

  assign out_free = !out_valid_q || out_o.ready;
  assign s3_free  = !s3_valid_q || out_free;
  assign s2_free  = !s2_valid_q || s3_free;
  assign s1_free  = !s1_valid_q || s2_free;

  assign in_i.ready = s1_free;
  assign cmd        = cmd_e'(in_i.cmd);
  assign in_acc     = in_i.valid && s1_free;
  assign sample_acc = in_acc && (cmd == CMD_SAMPLE);

  // envelope ramps
  logic [ENV_W:0]   env_sum;
  logic [ENV_W-1:0] env_up, env_dn;
  assign env_sum = {1'b0, env_q} + {1'b0, rise_q};
  assign env_up  = env_sum[ENV_W] ? {ENV_W{1'b1}} : env_sum[ENV_W-1:0];
  assign env_dn  = (env_q > fall_q) ? env_q - fall_q : '0;

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    env_d   = env_q;
    live_d  = live_q;
    if (in_acc) begin
      case (cmd)
        CMD_SAMPLE: begin
          if (env_q == '0) begin
            phase_d = '0;
            live_d  = 1'b0;
          end else begin
            phase_d = phase_q + step_q;
          end
        end
        CMD_ENV: begin
          env_d = (step_q != '0) ? env_up : env_dn;
        end
        CMD_STEP: begin
          step_d = in_i.phase_step;
          if (in_i.phase_step != '0) begin
            if (!live_q) begin
              phase_d = '0;
              live_d  = 1'b1;
            end
          end else begin
            live_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      env_q   <= '0;
      live_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      env_q   <= env_d;
      live_q  <= live_d;
    end
  end

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q     <= 8'd1;
      fall_q     <= 8'd1;
      duty_max_q <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_RISE:     rise_q     <= cfg_i.data[ENV_W-1:0];
        CFG_FALL:     fall_q     <= cfg_i.data[ENV_W-1:0];
        CFG_DUTY_MAX: duty_max_q <= cfg_i.data[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 -> 2: deviation from mid scale times envelope
  logic                 rom_hi;
  logic [DUTY_BITS-1:0] mag_full;
  logic [PROD_W-1:0]    prod_d;
  assign rom_hi   = s1_rom_q >= DUTY_MID;
  assign mag_full = rom_hi ? s1_rom_q - DUTY_MID : DUTY_MID - s1_rom_q;
  assign prod_d   = PROD_W'(mag_full[MAG_W-1:0]) * PROD_W'(s1_env_q);

  // stage 2 -> 3: divide by 255 through the reciprocal
  logic [SCL_W-1:0] scaled;
  assign scaled = SCL_W'(s2_prod_q) * SCL_W'(RECIP_255);

  // stage 3 -> out: apply sign, clamp; silent samples bypass the clamp
  logic [DUTY_BITS-1:0] duty_raw, duty_clamp, duty_d;
  assign duty_raw   = s3_neg_q ? DUTY_MID - DUTY_BITS'(s3_sc_q)
                               : DUTY_MID + DUTY_BITS'(s3_sc_q);
  assign duty_clamp = (duty_raw > duty_max_q) ? duty_max_q : duty_raw;
  assign duty_d     = (s3_env_q == '0) ? DUTY_MID : duty_clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= sample_acc;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (s3_free)  s3_valid_q  <= s2_valid_q;
      if (out_free) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      s1_rom_q <= SINE_ROM[phase_q[PHASE_W-1 -: IDX_W]];
      s1_env_q <= env_q;
    end
    if (s1_valid_q && s2_free) begin
      s2_prod_q <= prod_d;
      s2_neg_q  <= !rom_hi;
      s2_env_q  <= s1_env_q;
    end
    if (s2_valid_q && s3_free) begin
      s3_sc_q  <= scaled[RECIP_SHIFT +: MAG_W];
      s3_neg_q <= s2_neg_q;
      s3_env_q <= s2_env_q;
    end
    if (s3_valid_q && out_free) begin
      out_duty_q <= duty_d;
      out_env_q  <= s3_env_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.duty           = out_duty_q;
  assign out_o.envelope_level = out_env_q;
  assign out_o.active         = out_env_q != '0;

endmodule

@@ rtl/stse_checker.sv @@
// Port-level checks for the sine tone synthesizer, bound to the top level.
module stse_checker #(
  parameter int unsigned DUTY_BITS = stse_pkg::DUTY_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [stse_pkg::CMD_W-1:0]    in_cmd_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [DUTY_BITS-1:0]          out_duty_i,
  input logic [stse_pkg::ENV_W-1:0]    out_env_i,
  input logic                          out_active_i
);
  import stse_pkg::*;

  localparam logic [DUTY_BITS-1:0] DUTY_MID = {1'b1, {(DUTY_BITS-1){1'b0}}};

  // sample items accepted but not yet delivered
  logic [2:0] pending_q, pending_d;
  logic       smp_acc, res_acc;

  assign smp_acc = in_valid_i && in_ready_i && (in_cmd_i == CMD_SAMPLE);
  assign res_acc = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (smp_acc && !res_acc)      pending_d = pending_q + 3'd1;
    else if (!smp_acc && res_acc) pending_d = pending_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pending_q <= '0;
    else         pending_q <= pending_d;
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result without an outstanding sample item");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more sample items in flight than pipeline stages");

  a_silent_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_env_i == '0) |-> (out_duty_i == DUTY_MID && !out_active_i))
    else $error("silent sample not at mid scale");

  a_active_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_env_i != '0) |-> out_active_i)
    else $error("active flag disagrees with envelope level");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_duty_i)))
    else $error("stalled result changed");

endmodule

bind sine_tone_synth_with_envelope_top stse_checker #(
  .DUTY_BITS (DUTY_BITS)
) u_stse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_duty_i   (out_o.duty),
  .out_env_i    (out_o.envelope_level),
  .out_active_i (out_o.active)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the sine tone synthesizer with attack/release envelope.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stse_pkg::*;

  localparam int unsigned          SINE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int unsigned          MID_DUTY     = 1 << (DUTY_BITS_DEF - 1);
  localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
  localparam int unsigned          IDLE_LIMIT   = 1000;
  localparam int unsigned          SETTLE_CYC   = 8;
  localparam int unsigned          TARGET_ITEMS = 450;

  typedef struct packed {
    logic [DUTY_BITS_DEF-1:0] duty;
    logic [ENV_W-1:0]         level;
    logic                     active;
  } tone_t;

  logic clk_i;
  logic rst_ni;

  stse_in_if  in_bus ();
  stse_out_if out_bus ();
  stse_cfg_if cfg_bus ();

  sine_tone_synth_with_envelope_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // predictor state
  int unsigned    sine_tbl [SINE_DEPTH];
  logic [31:0]    phase;
  logic [31:0]    step;
  logic [ENV_W-1:0] env;
  logic           note_on;
  logic [7:0]     rise_amt;
  logic [7:0]     fall_amt;
  logic [9:0]     duty_ceiling;

  tone_t pending_tones[$];

  int unsigned items_sent;
  int unsigned tones_checked;
  int unsigned setups_done;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned burst_left;
  logic [15:0] stall_pat;
  int unsigned pat_pos;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // sin(pi/2 * r / SINE_DEPTH) in Q30 by Taylor series
  function automatic longint unsigned quarter_wave(int unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned k;
    x    = (longint'(r) * HALF_PI_Q30) / SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    pos  = 0;
    neg  = 0;
    k    = 1;
    for (int n = 0; n < 20 && term != 0; n++) begin
      if (n % 2 == 1) neg += term;
      else            pos += term;
      term = ((term * x2) >> 30) / ((k + 1) * (k + 2));
      k += 2;
    end
    if (neg >= pos) return 0;
    pos -= neg;
    return (pos > ONE_Q30) ? ONE_Q30 : pos;
  endfunction

  function automatic void fill_sine_tbl();
    int unsigned a;
    int unsigned quad;
    int unsigned r;
    longint unsigned s;
    int unsigned mag;
    for (int unsigned i = 0; i < SINE_DEPTH; i++) begin
      a    = 4 * i;
      quad = a / SINE_DEPTH;
      r    = a % SINE_DEPTH;
      s    = (quad % 2 == 1) ? quarter_wave(SINE_DEPTH - r) : quarter_wave(r);
      mag  = int'((s * (MID_DUTY - 1) + (ONE_Q30 >> 1)) >> 30);
      sine_tbl[i] = (quad >= 2) ? MID_DUTY - mag : MID_DUTY + mag;
    end
  endfunction

  // applies one accepted command to the predictor, queues the tone it produces
  function automatic void advance_synth(logic [CMD_W-1:0] c, logic [31:0] s);
    int unsigned sum;
    int unsigned v;
    int unsigned sc;
    int unsigned duty;
    tone_t t;
    case (c)
      CMD_ENV: begin
        if (step != 0) begin
          sum = env + rise_amt;
          env = (sum > 255) ? 8'd255 : sum[7:0];
        end else begin
          env = (env > fall_amt) ? env - fall_amt : 8'd0;
        end
      end
      CMD_STEP: begin
        step = s;
        if (s != 0) begin
          if (!note_on) begin
            phase   = '0;
            note_on = 1'b1;
          end
        end else begin
          note_on = 1'b0;
        end
      end
      CMD_SAMPLE: begin
        if (env == 0) begin
          phase   = '0;
          note_on = 1'b0;
          duty    = MID_DUTY;
        end else begin
          v = sine_tbl[phase[31:24]];
          if (v >= MID_DUTY) begin
            sc   = ((v - MID_DUTY) * env) / 255;
            duty = MID_DUTY + sc;
          end else begin
            sc   = ((MID_DUTY - v) * env) / 255;
            duty = MID_DUTY - sc;
          end
          if (duty > duty_ceiling) duty = duty_ceiling;
          phase = phase + step;
        end
        t.duty   = duty[DUTY_BITS_DEF-1:0];
        t.level  = env;
        t.active = (env != 0);
        pending_tones.push_back(t);
      end
      default: ;
    endcase
  endfunction

  // output side: stall pattern and result check
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= stall_pat[pat_pos % 16];
      pat_pos++;
    end
  end

  always @(posedge clk_i) begin : check_tones
    tone_t want;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_tones.size() == 0) begin
        $display("%0t: unexpected result duty=%0d level=%0d active=%0b", $time,
                 out_bus.duty, out_bus.envelope_level, out_bus.active);
        errors++;
      end else begin
        want = pending_tones.pop_front();
        tones_checked++;
        if (out_bus.duty !== want.duty) begin
          $display("%0t: duty expected %0d actual %0d", $time, want.duty, out_bus.duty);
          errors++;
        end
        if (out_bus.envelope_level !== want.level) begin
          $display("%0t: envelope_level expected %0d actual %0d", $time, want.level,
                   out_bus.envelope_level);
          errors++;
        end
        if (out_bus.active !== want.active) begin
          $display("%0t: active expected %0b actual %0b", $time, want.active,
                   out_bus.active);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // sends one command item; bursts with random gaps between them
  task automatic send_item(logic [CMD_W-1:0] c, logic [31:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= c;
    in_bus.phase_step <= s;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    advance_synth(c, s);
    if (c != CMD_UNUSED) items_sent++;
  endtask

  // stop sending and let every outstanding tone come back
  task automatic drain();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    case (idx)
      CFG_RISE:     rise_amt     = val[7:0];
      CFG_FALL:     fall_amt     = val[7:0];
      CFG_DUTY_MAX: duty_ceiling = val[9:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [7:0] rise, logic [7:0] fall, logic [9:0] dmax);
    drain();
    put_reg(CFG_RISE, CFG_DATA_W'(rise));
    put_reg(CFG_FALL, CFG_DATA_W'(fall));
    put_reg(CFG_DUTY_MAX, CFG_DATA_W'(dmax));
    cfg_bus.valid <= 1'b0;
    setups_done++;
  endtask

  function automatic logic [31:0] pick_step();
    logic [31:0] s;
    case ($urandom_range(0, 3))
      0:       s = $urandom_range(1, 4095);
      1:       s = 32'hFFFF_FFFF - $urandom_range(0, 4095);
      default: s = $urandom;
    endcase
    return (s == 0) ? 32'd1 : s;
  endfunction

  task automatic play_samples(int unsigned n);
    repeat (n) send_item(CMD_SAMPLE, $urandom);
  endtask

  // one note: load step, attack, optional retune, usually release, decay; sometimes noise
  task automatic play_note();
    if ($urandom_range(0, 5) == 0) begin
      repeat (5) send_item(CMD_W'($urandom_range(0, 3)), $urandom);
    end else begin
      send_item(CMD_STEP, pick_step());
      repeat ($urandom_range(1, 6)) begin
        send_item(CMD_ENV, $urandom);
        play_samples($urandom_range(0, 3));
      end
      if ($urandom_range(0, 3) == 0) send_item(CMD_STEP, pick_step());
      play_samples($urandom_range(1, 4));
      if ($urandom_range(0, 4) != 0) send_item(CMD_STEP, 32'd0);
      repeat ($urandom_range(0, 5)) begin
        send_item(CMD_ENV, $urandom);
        play_samples($urandom_range(0, 2));
      end
    end
  endtask

  // full scale envelope: silence at reset, sine extremes, retune
  task automatic test_directed_notes();
    load_settings(8'd255, 8'd255, 10'd1023);
    send_item(CMD_SAMPLE, 32'd0);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    send_item(CMD_STEP, 32'h4000_0000);
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF);   // envelope still zero: silent, phase reset
    send_item(CMD_ENV, 32'd0);
    play_samples(4);                        // quarter-turn steps hit peak and trough
    send_item(CMD_STEP, 32'h1000_0000);     // retune after the silent sample restarts the phase
    play_samples(2);
  endtask

  // clamp, zero envelope steps, release to silence, clamp at zero
  task automatic test_clamp_and_release();
    load_settings(8'd0, 8'd0, 10'd600);
    send_item(CMD_ENV, 32'd0);
    send_item(CMD_STEP, 32'h4000_0000);
    play_samples(3);
    send_item(CMD_STEP, 32'd0);
    send_item(CMD_ENV, 32'd0);
    send_item(CMD_SAMPLE, 32'd0);
    load_settings(8'd1, 8'd255, 10'd0);
    send_item(CMD_ENV, 32'd0);
    send_item(CMD_SAMPLE, 32'd0);
    send_item(CMD_STEP, 32'hFFFF_FFFF);
    send_item(CMD_ENV, 32'd0);
    play_samples(2);
  endtask

  task automatic test_random_phase(logic [7:0] rise, logic [7:0] fall, logic [9:0] dmax,
                                   logic [15:0] pat, int unsigned n);
    int unsigned stop_at;
    load_settings(rise, fall, dmax);
    stall_pat = pat;
    stop_at = items_sent + n;
    while (items_sent < stop_at) play_note();
  endtask

  task automatic test_random();
    test_random_phase(8'd1, 8'd1, 10'd1023, 16'hFFFF, 50);
    test_random_phase(8'd255, 8'd255, 10'd1023, 16'($urandom) | 16'h0101, 60);
    test_random_phase(8'd40, 8'd7, 10'd900, 16'h00FF, 50);
    test_random_phase(8'd255, 8'd1, 10'd512, 16'hFFFF, 50);
    test_random_phase(8'd3, 8'd255, 10'd100, 16'hA5A5, 50);
    test_random_phase(8'd128, 8'd64, 10'd0, 16'($urandom) | 16'h0101, 40);
    while (items_sent < TARGET_ITEMS)
      test_random_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                        10'($urandom_range(0, 1023)), 16'($urandom) | 16'h0101, 60);
  endtask

  initial begin
    int unsigned waited;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.cmd        = CMD_SAMPLE;
    in_bus.phase_step = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_RISE;
    cfg_bus.data      = '0;
    stall_pat     = 16'hFFFF;
    pat_pos       = 0;
    items_sent    = 0;
    tones_checked = 0;
    setups_done   = 0;
    errors        = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    phase         = '0;
    step          = '0;
    env           = '0;
    note_on       = 1'b0;
    rise_amt      = 8'd1;
    fall_amt      = 8'd1;
    duty_ceiling  = 10'd1023;
    fill_sine_tbl();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_notes();
    test_clamp_and_release();
    stall_pat = 16'h3F7D;
    test_random();

    in_bus.valid <= 1'b0;
    waited = 0;
    while (pending_tones.size() != 0 && waited < 500) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (pending_tones.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_tones.size());
      errors += pending_tones.size();
    end
    $display("Sent %0d commands across %0d register setups; %0d duty results checked.",
             items_sent, setups_done, tones_checked);
    $display("Covered silent envelope, clamping, retune, release and ignored codes.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/stse_pkg.sv
rtl/stse_ifs.sv
rtl/sine_tone_synth_with_envelope_top.sv
rtl/stse_checker.sv
test/tb_top.sv
